[hw/rtl/pbfl_pkg.sv]
// shared types and constants of the packet buffer free list
package pbfl_pkg;

    // default pool size
    localparam int POOL_DEPTH_DEFAULT = 1024;

    // field widths of the request and result beats
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOT_BUSY = 2'd2
    } t_status;

    // request beat
    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] buffer_index;
    } t_in_beat;

    // result beat
    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] granted_index;
        logic [COUNT_W-1:0] in_use_count;
        logic [COUNT_W-1:0] free_count;
    } t_out_beat;

    // classified request held in the queue between front and back
    typedef struct packed {
        logic               kind;
        logic               in_range;
        logic [INDEX_W-1:0] buffer_index;
    } t_cmd;

    // queue status seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

endpackage

[hw/rtl/pbfl_front.sv]
// request intake: accepts beats, checks the index range, queues commands
module pbfl_front #(
    parameter int POOL_DEPTH = pbfl_pkg::POOL_DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pbfl_pkg::t_in_beat i_in_beat,
    output pbfl_pkg::t_cmd_q   o_cmd_q,
    input  logic               i_pop
);
    import pbfl_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    t_cmd       w_cmd;

    // classify the incoming beat
    always_comb begin
        w_cmd.kind         = i_in_beat.kind;
        w_cmd.buffer_index = i_in_beat.buffer_index;
        w_cmd.in_range     = ({22'd0, i_in_beat.buffer_index} < 32'(POOL_DEPTH));
    end

    assign o_in_ready = (r_count != 2'd2);
    assign w_push     = i_in_valid && o_in_ready;

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_cmd_q.valid = (r_count != 2'd0);
    assign o_cmd_q.cmd   = r_q[r_rd_ptr];

endmodule

[hw/rtl/pbfl_back.sv]
// request execution: link and busy memories, head pointer, counters, result register
module pbfl_back #(
    parameter int POOL_DEPTH = pbfl_pkg::POOL_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pbfl_pkg::t_cmd_q    i_cmd_q,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pbfl_pkg::t_out_beat o_out_beat
);
    import pbfl_pkg::*;

    localparam int IW = $clog2(POOL_DEPTH);
    localparam int LW = $clog2(POOL_DEPTH + 1);

    typedef enum logic [1:0] {
        S_READ = 2'b01,
        S_EXEC = 2'b10
    } t_bstate;

    t_bstate   r_state, n_state;
    logic [LW-1:0] r_head, n_head;
    logic [LW-1:0] r_avail, n_avail;
    logic [LW-1:0] r_fill, n_fill;
    t_cmd      r_cmd;
    logic      r_fresh;
    logic      r_busy_known;
    logic [LW-1:0] r_link_q;
    logic      r_busy_q;
    logic      r_out_valid, n_out_valid;
    t_out_beat r_out_beat, n_out_beat;

    logic [LW-1:0] mem_link [POOL_DEPTH];
    logic          mem_busy [POOL_DEPTH];

    logic [IW+INDEX_W-1:0] w_new_ext;
    logic [IW+INDEX_W-1:0] w_cur_ext;
    logic [IW-1:0] w_new_addr;
    logic [IW-1:0] w_cur_addr;
    logic          w_slot_free;
    logic          w_link_we;
    logic          w_busy_we;
    logic          w_busy_wd;
    logic [IW-1:0] w_busy_wa;

    // buffer index of the queued and the latched command as memory addresses
    assign w_new_ext  = {{IW{1'b0}}, i_cmd_q.cmd.buffer_index};
    assign w_cur_ext  = {{IW{1'b0}}, r_cmd.buffer_index};
    assign w_new_addr = w_new_ext[IW-1:0];
    assign w_cur_addr = w_cur_ext[IW-1:0];

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_pop       = (r_state == S_READ) && i_cmd_q.valid;

    // execution and next state
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_avail     = r_avail;
        n_fill      = r_fill;
        n_out_valid = r_out_valid;
        n_out_beat  = r_out_beat;
        w_link_we   = 1'b0;
        w_busy_we   = 1'b0;
        w_busy_wd   = 1'b0;
        w_busy_wa   = w_cur_addr;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_READ: begin
                if (i_cmd_q.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    n_state                  = S_READ;
                    n_out_valid              = 1'b1;
                    n_out_beat.granted_index = '0;
                    if (r_cmd.kind == KIND_ALLOC) begin
                        if (r_avail == '0 || r_head >= LW'(POOL_DEPTH)) begin
                            n_out_beat.status = ST_EMPTY;
                        end else begin
                            // pop: a fresh buffer links to the next index
                            n_out_beat.status        = ST_DONE;
                            n_out_beat.granted_index = INDEX_W'(r_head);
                            n_head    = r_fresh ? (r_head + LW'(1)) : r_link_q;
                            n_avail   = r_avail - LW'(1);
                            n_fill    = r_fresh ? (r_fill + LW'(1)) : r_fill;
                            w_busy_we = 1'b1;
                            w_busy_wd = 1'b1;
                            w_busy_wa = r_head[IW-1:0];
                        end
                    end else begin
                        if (r_cmd.in_range && r_busy_known && r_busy_q) begin
                            // push the freed buffer onto the head
                            n_out_beat.status = ST_DONE;
                            n_head    = LW'(w_cur_addr);
                            w_link_we = 1'b1;
                            w_busy_we = 1'b1;
                            w_busy_wd = 1'b0;
                            if (r_avail < LW'(POOL_DEPTH)) begin
                                n_avail = r_avail + LW'(1);
                            end
                        end else begin
                            n_out_beat.status = ST_NOT_BUSY;
                        end
                    end
                    n_out_beat.free_count   = COUNT_W'(n_avail);
                    n_out_beat.in_use_count = COUNT_W'(LW'(POOL_DEPTH) - n_avail);
                end
            end
            default: begin
                n_state = S_READ;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_READ;
            r_head      <= '0;
            r_avail     <= LW'(POOL_DEPTH);
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_avail     <= n_avail;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // latched command, fresh-region flags and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd        <= i_cmd_q.cmd;
            r_fresh      <= (r_head >= r_fill);
            r_busy_known <= (LW'(w_new_addr) < r_fill);
        end
        r_out_beat <= n_out_beat;
    end

    // link memory: read at the head, written on free
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_link_q <= mem_link[r_head[IW-1:0]];
        end
        if (w_link_we) begin
            mem_link[w_cur_addr] <= r_head;
        end
    end

    // busy memory: read at the freed index, written on pop and free
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_busy_q <= mem_busy[w_new_addr];
        end
        if (w_busy_we) begin
            mem_busy[w_busy_wa] <= w_busy_wd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

[hw/rtl/packet_buffer_free_list_unit.sv]
// top level of the packet buffer free list allocator
// Each request beat (allocate, or free a given buffer) yields one result beat. The
// back end handles one request at a time in two steps: a registered read of the
// link and busy memories, then an update of the head pointer and counters and a load
// of the result register, which waits while that register is still full. It takes
// no new request before it is through with the last one. A two-beat queue ahead of
// the back end and the result register let either side stall on its own. Untouched
// buffers are tracked by a fill count instead of a clearing pass, so the block takes requests right after reset.
module packet_buffer_free_list_unit #(
    parameter int POOL_DEPTH = pbfl_pkg::POOL_DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pbfl_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pbfl_pkg::t_out_beat o_out_beat
);
    import pbfl_pkg::*;

    t_cmd_q w_cmd_q;
    logic   w_pop;

    // intake and queue
    pbfl_front #(
        .POOL_DEPTH(POOL_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .o_cmd_q    (w_cmd_q),
        .i_pop      (w_pop)
    );

    // execution
    pbfl_back #(
        .POOL_DEPTH(POOL_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_q     (w_cmd_q),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

`ifndef SYNTHESIS
    // counts always add up to the pool size
    a_counts_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (COUNT_W'(o_out_beat.in_use_count + o_out_beat.free_count)
             == COUNT_W'(POOL_DEPTH)))
        else $error("in-use and free counts do not sum to pool size");

    // nothing granted unless an allocate succeeded
    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status != ST_DONE) |->
            (o_out_beat.granted_index == '0))
        else $error("buffer index granted on a failed request");

    // pool empty is only reported with no free buffers
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status == ST_EMPTY && POOL_DEPTH < 2048) |->
            (o_out_beat.free_count == '0))
        else $error("pool empty reported with free buffers left");

    // the queue is never popped while empty
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_cmd_q.valid)
        else $error("command queue popped while empty");
`endif

endmodule
